// File: src/chr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chr_pkg
// Shared types and constants of the hash ring unit: transfer payloads,
// opcodes, result kinds, hash constants, controller states, commands and status.
// ----------------------------------------------------------------------------
package chr_pkg;

    // opcodes of an input transfer
    localparam logic [1:0] OP_LOOKUP    = 2'd0;
    localparam logic [1:0] OP_INSERT    = 2'd1;
    localparam logic [1:0] OP_REMOVE    = 2'd2;
    localparam logic [1:0] OP_REBALANCE = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_LOOKUP = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;
    localparam logic [1:0] KIND_TASK   = 2'd3;

    // hash constants
    localparam logic [63:0] FNV_BASIS  = 64'hcbf29ce484222325;
    localparam logic [8:0]  FNV_LOW    = 9'h1b3;  // prime is 2^40 + 0x1b3
    localparam int          FNV_SHIFT  = 40;
    localparam logic [63:0] MIX_C1     = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MIX_C2     = 64'hc4ceb9fe1a85ec53;
    localparam int          MIX_SHIFT  = 33;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] key_byte;
        logic       last;
        logic [7:0] owner_id;
    } t_in;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic        found;
        logic [7:0]  owner;
        logic [63:0] range_start;
        logic [63:0] range_end;
        logic [8:0]  drop_count;
    } t_out;

    typedef enum logic [4:0] {
        S_IDLE,
        S_X0,
        S_A1, S_B1, S_C1, S_X1,
        S_A2, S_B2, S_C2, S_X2,
        S_SCAN0, S_SCAN, S_DECIDE,
        S_INS_SH, S_INS_WR,
        S_RB_PREV, S_RB_WALK,
        S_RM, S_RM_RES,
        S_EMIT
    } t_state;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_BYTE,
        CMD_RM_START,
        CMD_MIX_X0,
        CMD_MUL_LL,
        CMD_MUL_LH,
        CMD_MUL_HL,
        CMD_MIX_XP,
        CMD_SCAN_START,
        CMD_SCAN_STEP,
        CMD_LK_RES,
        CMD_INS_HIT,
        CMD_INS_FULL,
        CMD_INS_SH_START,
        CMD_INS_SH,
        CMD_INS_WR,
        CMD_RB_PREV,
        CMD_RB_START,
        CMD_RB_STEP,
        CMD_RM_STEP,
        CMD_RM_RES,
        CMD_EMIT
    } t_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic csel;   // selects the second mixer constant
    } t_ctl;

    typedef struct packed {
        logic [1:0] op;
        logic       empty;
        logic       full;
        logic       ge;
        logic       idx_last;
        logic       at_p;
        logic       p_in;
        logic       eq;
        logic       p_eq_cnt;
        logic       start_eq;
        logic       owner_diff;
        logic       k_last;
        logic       out_free;
    } t_sts;

endpackage

// File: src/chr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chr_datapath
// Running hash, shared 32x32 multiplier for the finalizer, the sorted ring
// memory with its pointers, and the result and output registers.
// ----------------------------------------------------------------------------
module chr_datapath #(
    parameter int RING_ENTRIES = 256,
    parameter int OWNER_BITS   = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  chr_pkg::t_in  i_data,
    input  chr_pkg::t_ctl i_ctl,
    input  logic        i_stall,
    output chr_pkg::t_sts o_sts,
    output logic        o_valid,
    output chr_pkg::t_out o_data
);
    import chr_pkg::*;

    localparam int IW = $clog2(RING_ENTRIES);
    localparam int CW = $clog2(RING_ENTRIES + 1);
    localparam int MW = 64 + OWNER_BITS;

    // ring memory
    logic [MW-1:0] r_mem [RING_ENTRIES];
    logic [MW-1:0] r_q;
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    logic [MW-1:0] mem_wd;

    logic [63:0]           r_hash, n_hash;
    logic [63:0]           r_m, n_m;
    logic [63:0]           r_pp, n_pp;
    logic [1:0]            r_op, n_op;
    logic [OWNER_BITS-1:0] r_who, n_who;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [CW-1:0]         r_idx, n_idx;
    logic [CW-1:0]         r_w, n_w;
    logic [CW-1:0]         r_p, n_p;
    logic [CW-1:0]         r_k, n_k;
    logic [CW-1:0]         r_removed, n_removed;
    logic                  r_eq, n_eq;
    logic [OWNER_BITS-1:0] r_first_owner, n_first_owner;
    logic [OWNER_BITS-1:0] r_hit_owner, n_hit_owner;
    logic [63:0]           r_start, n_start;
    t_out                  r_res, n_res;
    t_out                  r_out, n_out;
    logic                  r_ov, n_ov;

    logic [63:0]           q_hash;
    logic [OWNER_BITS-1:0] q_owner;
    logic [63:0]           fold_x;
    logic [72:0]           fold_lo;
    logic [63:0]           folded;
    logic [63:0]           mconst;
    logic [31:0]           mul_a, mul_b;
    logic [63:0]           mul_p;
    logic [CW-1:0]         idx_inc;
    logic [CW-1:0]         p_inc;

    assign q_hash  = r_q[MW-1:OWNER_BITS];
    assign q_owner = r_q[OWNER_BITS-1:0];

    // fnv-1a step with sign-extended byte
    assign fold_x  = r_hash ^ {{56{i_data.key_byte[7]}}, i_data.key_byte};
    assign fold_lo = fold_x * FNV_LOW;
    assign folded  = (fold_x << FNV_SHIFT) + fold_lo[63:0];

    // shared multiplier operand selection
    assign mconst = i_ctl.csel ? MIX_C2 : MIX_C1;
    always_comb begin
        unique case (i_ctl.cmd)
            CMD_MUL_LH: begin
                mul_a = r_m[31:0];
                mul_b = mconst[63:32];
            end
            CMD_MUL_HL: begin
                mul_a = r_m[63:32];
                mul_b = mconst[31:0];
            end
            default: begin
                mul_a = r_m[31:0];
                mul_b = mconst[31:0];
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    assign idx_inc = o_sts.idx_last ? '0 : r_idx + CW'(1);
    assign p_inc   = (r_p + CW'(1) == r_cnt) ? '0 : r_p + CW'(1);

    // status toward the controller
    always_comb begin
        o_sts.op         = r_op;
        o_sts.empty      = (r_cnt == '0);
        o_sts.full       = (r_cnt == CW'(RING_ENTRIES));
        o_sts.ge         = (q_hash >= r_m);
        o_sts.idx_last   = (r_idx + CW'(1) == r_cnt);
        o_sts.at_p       = (r_idx == r_p);
        o_sts.p_in       = (r_p < r_cnt);
        o_sts.eq         = r_eq;
        o_sts.p_eq_cnt   = (r_p == r_cnt);
        o_sts.start_eq   = (q_hash == r_m);
        o_sts.owner_diff = (q_owner != r_who);
        o_sts.k_last     = (r_k == r_cnt);
        o_sts.out_free   = !r_ov || !i_stall;
    end

    // command decode
    always_comb begin
        n_hash        = r_hash;
        n_m           = r_m;
        n_pp          = r_pp;
        n_op          = r_op;
        n_who         = r_who;
        n_cnt         = r_cnt;
        n_idx         = r_idx;
        n_w           = r_w;
        n_p           = r_p;
        n_k           = r_k;
        n_removed     = r_removed;
        n_eq          = r_eq;
        n_first_owner = r_first_owner;
        n_hit_owner   = r_hit_owner;
        n_start       = r_start;
        n_res         = r_res;
        n_out         = r_out;
        n_ov          = r_ov && i_stall;
        mem_we        = 1'b0;
        mem_wa        = r_idx[IW-1:0];
        mem_wd        = r_q;
        unique case (i_ctl.cmd)
            CMD_BYTE: begin
                n_op  = i_data.opcode;
                n_who = OWNER_BITS'(i_data.owner_id);
                if (i_data.last) begin
                    n_m    = folded;
                    n_hash = FNV_BASIS;
                end else begin
                    n_hash = folded;
                end
            end
            CMD_RM_START: begin
                n_who     = OWNER_BITS'(i_data.owner_id);
                n_hash    = FNV_BASIS;
                n_idx     = '0;
                n_w       = '0;
                n_removed = '0;
            end
            CMD_MIX_X0: n_m = r_m ^ (r_m >> MIX_SHIFT);
            CMD_MUL_LL: n_pp = mul_p;
            CMD_MUL_LH, CMD_MUL_HL: n_pp[63:32] = r_pp[63:32] + mul_p[31:0];
            CMD_MIX_XP: n_m = r_pp ^ (r_pp >> MIX_SHIFT);
            CMD_SCAN_START: begin
                n_idx = '0;
                n_p   = r_cnt;
                n_eq  = 1'b0;
            end
            CMD_SCAN_STEP: begin
                if (r_idx == '0) begin
                    n_first_owner = q_owner;
                end
                if (o_sts.ge) begin
                    n_p         = r_idx;
                    n_eq        = o_sts.start_eq;
                    n_hit_owner = q_owner;
                end else if (!o_sts.idx_last) begin
                    n_idx = r_idx + CW'(1);
                end
            end
            CMD_LK_RES: begin
                n_res = '0;
                n_res.result_kind = KIND_LOOKUP;
                n_res.found = !o_sts.empty;
                if (!o_sts.empty) begin
                    n_res.owner = o_sts.p_in ? 8'(r_hit_owner) : 8'(r_first_owner);
                end
            end
            CMD_INS_HIT: begin
                mem_we = 1'b1;
                mem_wa = r_p[IW-1:0];
                mem_wd = {r_m, r_who};
                n_res = '0;
                n_res.result_kind = KIND_INSERT;
                n_res.found = 1'b1;
            end
            CMD_INS_FULL: begin
                n_res = '0;
                n_res.result_kind = KIND_INSERT;
            end
            CMD_INS_SH_START: n_idx = r_cnt - CW'(1);
            CMD_INS_SH: begin
                mem_we = 1'b1;
                mem_wa = IW'(r_idx + CW'(1));
                mem_wd = r_q;
                if (!o_sts.at_p) begin
                    n_idx = r_idx - CW'(1);
                end
            end
            CMD_INS_WR: begin
                mem_we = 1'b1;
                mem_wa = r_p[IW-1:0];
                mem_wd = {r_m, r_who};
                n_cnt  = r_cnt + CW'(1);
                n_res = '0;
                n_res.result_kind = KIND_INSERT;
                n_res.found = 1'b1;
            end
            CMD_RB_PREV: n_idx = (r_p == '0) ? r_cnt - CW'(1) : r_p - CW'(1);
            CMD_RB_START: begin
                n_start = q_hash;
                n_idx   = p_inc;
                n_k     = CW'(1);
            end
            CMD_RB_STEP: begin
                if (o_sts.owner_diff) begin
                    n_res.result_kind = KIND_TASK;
                    n_res.found       = 1'b1;
                    n_res.owner       = 8'(q_owner);
                    n_res.range_start = r_start;
                    n_res.range_end   = r_m;
                    n_res.drop_count  = '0;
                end else begin
                    n_k   = r_k + CW'(1);
                    n_idx = idx_inc;
                end
            end
            CMD_RM_STEP: begin
                if (o_sts.owner_diff) begin
                    mem_we = 1'b1;
                    mem_wa = r_w[IW-1:0];
                    mem_wd = r_q;
                    n_w    = r_w + CW'(1);
                end else begin
                    n_removed = r_removed + CW'(1);
                end
                if (o_sts.idx_last) begin
                    n_cnt = o_sts.owner_diff ? r_w + CW'(1) : r_w;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            CMD_RM_RES: begin
                n_res = '0;
                n_res.result_kind = KIND_REMOVE;
                n_res.found       = (r_removed != '0);
                n_res.drop_count  = 9'(r_removed);
            end
            CMD_EMIT: begin
                n_out = r_res;
                n_ov  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // ring memory with registered read at the next index
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_q <= r_mem[n_idx[IW-1:0]];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= FNV_BASIS;
            r_cnt  <= '0;
            r_ov   <= 1'b0;
        end else begin
            r_hash <= n_hash;
            r_cnt  <= n_cnt;
            r_ov   <= n_ov;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_m           <= n_m;
        r_pp          <= n_pp;
        r_op          <= n_op;
        r_who         <= n_who;
        r_idx         <= n_idx;
        r_w           <= n_w;
        r_p           <= n_p;
        r_k           <= n_k;
        r_removed     <= n_removed;
        r_eq          <= n_eq;
        r_first_owner <= n_first_owner;
        r_hit_owner   <= n_hit_owner;
        r_start       <= n_start;
        r_res         <= n_res;
        r_out         <= n_out;
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

endmodule

// File: src/chr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chr_ctrl
// Sequencer of the hash ring unit: byte intake, finalizer steps, table
// scan, insert shift, rebalance walk, remove compaction and result hand-off.
// ----------------------------------------------------------------------------
module chr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  chr_pkg::t_in  i_data,
    input  chr_pkg::t_sts i_sts,
    output logic          o_stall,
    output chr_pkg::t_ctl o_ctl
);
    import chr_pkg::*;

    t_state r_state, n_state;
    logic   take;

    assign take = i_valid && (r_state == S_IDLE);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    if (i_data.opcode == OP_REMOVE) begin
                        n_state = S_RM;
                    end else if (i_data.last) begin
                        n_state = S_X0;
                    end
                end
            end
            S_X0:  n_state = S_A1;
            S_A1:  n_state = S_B1;
            S_B1:  n_state = S_C1;
            S_C1:  n_state = S_X1;
            S_X1:  n_state = S_A2;
            S_A2:  n_state = S_B2;
            S_B2:  n_state = S_C2;
            S_C2:  n_state = S_X2;
            S_X2:  n_state = S_SCAN0;
            S_SCAN0: n_state = i_sts.empty ? S_DECIDE : S_SCAN;
            S_SCAN: begin
                if (i_sts.ge || i_sts.idx_last) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                priority if (i_sts.op == OP_LOOKUP) begin
                    n_state = S_EMIT;
                end else if (i_sts.op == OP_INSERT) begin
                    priority if (i_sts.p_in && i_sts.eq) n_state = S_EMIT;
                    else if (i_sts.full)                 n_state = S_EMIT;
                    else if (i_sts.p_eq_cnt)             n_state = S_INS_WR;
                    else                                 n_state = S_INS_SH;
                end else if (i_sts.op == OP_REBALANCE) begin
                    if (i_sts.empty || !i_sts.p_in || !i_sts.eq) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_RB_PREV;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_INS_SH:  if (i_sts.at_p) n_state = S_INS_WR;
            S_INS_WR:  n_state = S_EMIT;
            S_RB_PREV: n_state = i_sts.start_eq ? S_IDLE : S_RB_WALK;
            S_RB_WALK: begin
                if (i_sts.owner_diff) begin
                    n_state = S_EMIT;
                end else if (i_sts.k_last) begin
                    n_state = S_IDLE;
                end
            end
            S_RM: begin
                if (i_sts.empty || i_sts.idx_last) begin
                    n_state = S_RM_RES;
                end
            end
            S_RM_RES: n_state = S_EMIT;
            S_EMIT:   if (i_sts.out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ctl.cmd  = CMD_NONE;
        o_ctl.csel = (r_state == S_A2) || (r_state == S_B2) || (r_state == S_C2);
        o_stall    = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    o_ctl.cmd = (i_data.opcode == OP_REMOVE) ? CMD_RM_START : CMD_BYTE;
                end
            end
            S_X0:  o_ctl.cmd = CMD_MIX_X0;
            S_A1, S_A2: o_ctl.cmd = CMD_MUL_LL;
            S_B1, S_B2: o_ctl.cmd = CMD_MUL_LH;
            S_C1, S_C2: o_ctl.cmd = CMD_MUL_HL;
            S_X1, S_X2: o_ctl.cmd = CMD_MIX_XP;
            S_SCAN0: o_ctl.cmd = CMD_SCAN_START;
            S_SCAN:  o_ctl.cmd = CMD_SCAN_STEP;
            S_DECIDE: begin
                priority if (i_sts.op == OP_LOOKUP) begin
                    o_ctl.cmd = CMD_LK_RES;
                end else if (i_sts.op == OP_INSERT) begin
                    priority if (i_sts.p_in && i_sts.eq) o_ctl.cmd = CMD_INS_HIT;
                    else if (i_sts.full)                 o_ctl.cmd = CMD_INS_FULL;
                    else if (i_sts.p_eq_cnt)             o_ctl.cmd = CMD_NONE;
                    else                                 o_ctl.cmd = CMD_INS_SH_START;
                end else if (i_sts.op == OP_REBALANCE) begin
                    if (!(i_sts.empty || !i_sts.p_in || !i_sts.eq)) begin
                        o_ctl.cmd = CMD_RB_PREV;
                    end
                end else begin
                    o_ctl.cmd = CMD_NONE;
                end
            end
            S_INS_SH:  o_ctl.cmd = CMD_INS_SH;
            S_INS_WR:  o_ctl.cmd = CMD_INS_WR;
            S_RB_PREV: if (!i_sts.start_eq) o_ctl.cmd = CMD_RB_START;
            S_RB_WALK: o_ctl.cmd = CMD_RB_STEP;
            S_RM:      if (!i_sts.empty) o_ctl.cmd = CMD_RM_STEP;
            S_RM_RES:  o_ctl.cmd = CMD_RM_RES;
            S_EMIT:    if (i_sts.out_free) o_ctl.cmd = CMD_EMIT;
            default:   o_ctl.cmd = CMD_NONE;
        endcase
    end

endmodule

// File: src/consistent_hash_ring_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// consistent_hash_ring_unit
// Streaming key hasher (FNV-1a 64 plus fmix64) in front of a sorted ring of
// hash/owner entries supporting lookup, insert, remove and rebalance.
// ----------------------------------------------------------------------------
// Timing: a key byte that is not the last one only updates the running hash.
// The last byte of a key adds finalizer work (three 32x32 partial products
// per mixer constant on one shared multiplier) and then a linear scan of the
// ring memory at one entry per cycle, up to the entry count. An insert that
// lands inside the ring first shifts the entries above it up, a rebalance
// walks up to the entry count once more, and a remove compacts the ring entry
// by entry. A result waits in an output register, so the next key is taken
// while it is held; the single-port-read ring memory sets the per-entry pace.
module consistent_hash_ring_unit #(
    parameter int RING_ENTRIES = 256,
    parameter int OWNER_BITS   = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  chr_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output chr_pkg::t_out o_data
);
    import chr_pkg::*;

    t_ctl ctl;
    t_sts sts;

    chr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .i_sts   (sts),
        .o_stall (o_stall),
        .o_ctl   (ctl)
    );

    chr_datapath #(
        .RING_ENTRIES (RING_ENTRIES),
        .OWNER_BITS   (OWNER_BITS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (i_data),
        .i_ctl   (ctl),
        .i_stall (i_stall),
        .o_sts   (sts),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

endmodule

// File: verif/consistent_hash_ring_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// consistent_hash_ring_unit_test
// Self-checking bench for the hash ring unit. Streams keys for lookup, insert,
// remove and rebalance, keeps its own copy of the ring and the running hash,
// and checks every result transfer field by field, in order, under random
// idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module consistent_hash_ring_unit_test;
    import chr_pkg::*;

    localparam int N_ENTRIES  = 256;
    localparam int CYCLE_CAP  = 3000000;
    localparam int DRAIN_CYC  = 2000;
    localparam int CALM_TAIL  = 120;
    localparam int HOLD_AT    = 400;
    localparam int HOLD_LEN   = 600;
    localparam logic [63:0] FNV_MUL = 64'd1099511628211;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in  i_data;
    logic o_valid;
    logic i_stall;
    t_out o_data;

    consistent_hash_ring_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data)
    );

    // ring mirror and hash accumulator
    logic [63:0] ring_hash[N_ENTRIES];
    logic [7:0]  ring_owner[N_ENTRIES];
    int          ring_cnt;
    logic [63:0] fnv_acc;

    t_in  pending_items[$];
    t_out expected_results[$];
    logic [25:0] known_keys[$];   // {length, up to three key bytes}

    int  n_sent, n_checked, n_errors, n_cycles;
    int  n_kind[4];
    bit  in_took;
    int  send_gap, recv_gap, hold_left;
    bit  hold_done;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [63:0] mix64(logic [63:0] h);
        h = h ^ (h >> 33);
        h = h * MIX_C1;
        h = h ^ (h >> 33);
        h = h * MIX_C2;
        h = h ^ (h >> 33);
        return h;
    endfunction

    // append to the stimulus and expectation queues
    task automatic add_item(input t_in it);
        pending_items = {pending_items, it};
    endtask

    task automatic add_expected(input t_out r);
        expected_results = {expected_results, r};
    endtask

    // apply one accepted transfer to the mirror, queue the result it causes
    task automatic ring_apply(input t_in it);
        t_out r;
        logic [63:0] ext, h, rstart;
        int p, w, nrem, idx;
        r = '0;
        if (it.opcode == OP_REMOVE) begin
            fnv_acc = FNV_BASIS;
            w = 0;
            nrem = 0;
            for (int i = 0; i < ring_cnt; i++) begin
                if (ring_owner[i] == it.owner_id) begin
                    nrem++;
                end else begin
                    ring_hash[w] = ring_hash[i];
                    ring_owner[w] = ring_owner[i];
                    w++;
                end
            end
            ring_cnt = w;
            r.result_kind = KIND_REMOVE;
            r.found = (nrem > 0);
            r.drop_count = nrem[8:0];
            add_expected(r);
            return;
        end
        ext = {{56{it.key_byte[7]}}, it.key_byte};
        fnv_acc = (fnv_acc ^ ext) * FNV_MUL;
        if (!it.last) return;
        h = mix64(fnv_acc);
        fnv_acc = FNV_BASIS;
        p = 0;
        while (p < ring_cnt && ring_hash[p] < h) p++;
        case (it.opcode)
            OP_LOOKUP: begin
                r.result_kind = KIND_LOOKUP;
                if (ring_cnt != 0) begin
                    r.found = 1'b1;
                    r.owner = ring_owner[(p >= ring_cnt) ? 0 : p];
                end
                add_expected(r);
            end
            OP_INSERT: begin
                r.result_kind = KIND_INSERT;
                r.found = 1'b1;
                if (p < ring_cnt && ring_hash[p] == h) begin
                    ring_owner[p] = it.owner_id;
                end else if (ring_cnt >= N_ENTRIES) begin
                    r.found = 1'b0;
                end else begin
                    for (int i = ring_cnt; i > p; i--) begin
                        ring_hash[i] = ring_hash[i-1];
                        ring_owner[i] = ring_owner[i-1];
                    end
                    ring_hash[p] = h;
                    ring_owner[p] = it.owner_id;
                    ring_cnt++;
                end
                add_expected(r);
            end
            default: begin
                if (ring_cnt == 0 || p >= ring_cnt || ring_hash[p] != h) return;
                rstart = (p == 0) ? ring_hash[ring_cnt-1] : ring_hash[p-1];
                if (rstart == h) return;
                for (int k = 1; k <= ring_cnt; k++) begin
                    idx = (p + k) % ring_cnt;
                    if (ring_owner[idx] != it.owner_id) begin
                        r.result_kind = KIND_TASK;
                        r.found = 1'b1;
                        r.owner = ring_owner[idx];
                        r.range_start = rstart;
                        r.range_end = h;
                        add_expected(r);
                        return;
                    end
                end
            end
        endcase
    endtask

    // queue one key: non-last bytes carry a random non-remove opcode
    task automatic queue_key(input logic [1:0] op, input logic [25:0] key,
                             input logic [7:0] who);
        t_in it;
        int len;
        len = key[25:24];
        for (int i = 0; i < len; i++) begin
            it.key_byte = key[8*i +: 8];
            it.last = (i == len - 1);
            it.owner_id = who;
            if (it.last) begin
                it.opcode = op;
            end else begin
                case ($urandom_range(0, 2))
                    0: it.opcode = OP_LOOKUP;
                    1: it.opcode = OP_INSERT;
                    default: it.opcode = OP_REBALANCE;
                endcase
            end
            add_item(it);
        end
        if (op == OP_INSERT) known_keys = {known_keys, key};
    endtask

    task automatic queue_remove(input logic [7:0] who);
        t_in it;
        it.opcode = OP_REMOVE;
        it.key_byte = 8'($urandom_range(0, 255));
        it.last = 1'($urandom_range(0, 1));
        it.owner_id = who;
        add_item(it);
    endtask

    function automatic logic [25:0] rand_key();
        logic [1:0] len;
        len = 2'($urandom_range(1, 3));
        return {len, 24'($urandom())};
    endfunction

    function automatic logic [7:0] rand_owner();
        return ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 7))
                                          : 8'($urandom_range(0, 255));
    endfunction

    // input driver: acceptance seen at the rising edge, next transfer set up
    // at the falling edge
    always @(posedge i_clk) in_took <= i_rst_n && i_valid && !o_stall;

    always @(negedge i_clk) begin
        logic nxt_valid;
        t_in  nxt_data;
        nxt_valid = i_valid;
        nxt_data = i_data;
        if (in_took) begin
            ring_apply(i_data);
            n_sent++;
            nxt_valid = 1'b0;
        end
        if (i_rst_n && !nxt_valid) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_items.size() > 0) begin
                if (pending_items.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(1, 10);
                end else begin
                    nxt_data = pending_items.pop_front();
                    nxt_valid = 1'b1;
                end
            end
        end
        i_valid <= nxt_valid;
        i_data <= nxt_data;
    end

    // output stall: random bursts plus one long hold-off
    always @(negedge i_clk) begin
        logic nxt_stall;
        nxt_stall = 1'b0;
        if (!hold_done && n_sent >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            nxt_stall = 1'b1;
        end else if (recv_gap > 0) begin
            recv_gap--;
            nxt_stall = 1'b1;
        end else if (pending_items.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(0, 9);
            nxt_stall = 1'b1;
        end
        i_stall <= nxt_stall;
    end

    // result checker
    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result transfer: kind %0d", o_data.result_kind);
                n_errors++;
            end else begin
                exp_r = expected_results.pop_front();
                n_checked++;
                n_kind[exp_r.result_kind]++;
                if (o_data.result_kind !== exp_r.result_kind) begin
                    $error("result_kind: expected %0d, got %0d",
                           exp_r.result_kind, o_data.result_kind);
                    n_errors++;
                end
                if (o_data.found !== exp_r.found) begin
                    $error("found: expected %0d, got %0d", exp_r.found, o_data.found);
                    n_errors++;
                end
                if (o_data.owner !== exp_r.owner) begin
                    $error("owner: expected %0d, got %0d", exp_r.owner, o_data.owner);
                    n_errors++;
                end
                if (o_data.range_start !== exp_r.range_start) begin
                    $error("range_start: expected %h, got %h",
                           exp_r.range_start, o_data.range_start);
                    n_errors++;
                end
                if (o_data.range_end !== exp_r.range_end) begin
                    $error("range_end: expected %h, got %h",
                           exp_r.range_end, o_data.range_end);
                    n_errors++;
                end
                if (o_data.drop_count !== exp_r.drop_count) begin
                    $error("drop_count: expected %0d, got %0d",
                           exp_r.drop_count, o_data.drop_count);
                    n_errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", n_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        logic [25:0] ka, kb, kc;
        int pick;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_data = '0;
        in_took = 1'b0;
        n_sent = 0; n_checked = 0; n_errors = 0; n_cycles = 0;
        n_kind = '{default: 0};
        send_gap = 0; recv_gap = 0; hold_left = 0; hold_done = 1'b0;
        ring_cnt = 0;
        fnv_acc = FNV_BASIS;

        // directed: empty ring, single entry, one owner only, partial key
        // dropped by a remove, byte extremes and owner extremes
        ka = {2'd1, 24'h000000};
        kb = {2'd2, 24'h00ff80};
        kc = {2'd3, 24'h7f01ff};
        queue_key(OP_LOOKUP, ka, 8'd0);
        queue_key(OP_REBALANCE, ka, 8'd0);
        queue_remove(8'd3);
        queue_key(OP_INSERT, ka, 8'd5);
        queue_key(OP_REBALANCE, ka, 8'd9);
        queue_key(OP_INSERT, kb, 8'd5);
        queue_key(OP_REBALANCE, ka, 8'd5);
        queue_key(OP_REBALANCE, ka, 8'd255);
        queue_key(OP_INSERT, kc, 8'd255);
        queue_key(OP_REBALANCE, kc, 8'd5);
        queue_key(OP_REBALANCE, {2'd1, 24'h000055}, 8'd1);
        queue_key(OP_LOOKUP, kc, 8'd0);
        queue_key(OP_INSERT, kb, 8'd170);
        queue_key(OP_LOOKUP, {2'd2, 24'h0080ff}, 8'd0);
        add_item(t_in'{opcode: OP_INSERT, key_byte: 8'h12, last: 1'b0,
                       owner_id: 8'd0});
        queue_remove(8'd255);
        queue_key(OP_LOOKUP, ka, 8'd0);
        queue_remove(8'd5);
        queue_remove(8'd170);

        // fill the ring to capacity, then a miss and an overwrite when full
        for (int b = 0; b < 256; b++) queue_key(OP_INSERT, {2'd1, 16'h0, 8'(b)}, rand_owner());
        queue_key(OP_INSERT, {2'd3, 24'habcdef}, 8'd1);
        queue_key(OP_INSERT, {2'd1, 24'h000080}, 8'd2);
        queue_key(OP_LOOKUP, rand_key(), 8'd0);
        for (int o = 0; o < 8; o++) queue_remove(8'(o));

        // random mix, mostly well-formed keys, reusing stored keys often
        for (int n = 0; n < 260; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 33) begin
                queue_key(OP_INSERT, ($urandom_range(0, 3) == 0 && known_keys.size() > 0)
                          ? known_keys[$urandom_range(0, known_keys.size() - 1)]
                          : rand_key(), rand_owner());
            end else if (pick < 60) begin
                queue_key(OP_LOOKUP, ($urandom_range(0, 1) == 0)
                          ? known_keys[$urandom_range(0, known_keys.size() - 1)]
                          : rand_key(), rand_owner());
            end else if (pick < 88) begin
                queue_key(OP_REBALANCE, ($urandom_range(0, 4) != 0)
                          ? known_keys[$urandom_range(0, known_keys.size() - 1)]
                          : rand_key(), rand_owner());
            end else begin
                queue_remove(rand_owner());
            end
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (pending_items.size() == 0 && !i_valid && expected_results.size() == 0);
        repeat (DRAIN_CYC) @(posedge i_clk);

        $display("sent %0d transfers, checked %0d results", n_sent, n_checked);
        $display("lookups %0d, inserts %0d, removes %0d, migration tasks %0d",
                 n_kind[KIND_LOOKUP], n_kind[KIND_INSERT], n_kind[KIND_REMOVE],
                 n_kind[KIND_TASK]);
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
